// ===== hw/rtl/dlg_pkg.sv =====
// Shared types, constants and register map of the DVFS load governor step.
`default_nettype none
package dlg_pkg;

  localparam int FREQ_W = 24;
  localparam int IVL_W  = 27;
  localparam int PCT_W  = 7;
  localparam int DIV_W  = 32;
  localparam int DVS_W  = 7;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int CNT_W  = $clog2(DIV_STEPS);
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [PCT_W-1:0] IDLE_LOAD = 7'd5;
  localparam logic [PCT_W-1:0] DROP_PCT  = 7'd15;
  localparam logic [DVS_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [IVL_W-1:0] IVL_MAX   = 27'h7FFFFFF;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 24'hFFFFFF;

  localparam logic [31:0] RECIP_100 = 32'd2748779070;
  localparam int          RECIP_SH  = 38;

  localparam logic [1:0] REL_NONE     = 2'd0;
  localparam logic [1:0] REL_AT_BELOW = 2'd1;
  localparam logic [1:0] REL_AT_ABOVE = 2'd2;

  localparam logic [2:0] REG_RAISE_LOAD = 3'd0;
  localparam logic [2:0] REG_BOOST_PCT  = 3'd1;
  localparam logic [2:0] REG_FAST_DIV   = 3'd2;
  localparam logic [2:0] REG_SLOW_MULT  = 3'd3;
  localparam logic [2:0] REG_BASE_IVL   = 3'd4;
  localparam logic [2:0] REG_FLOOR_IVL  = 3'd5;
  localparam logic [2:0] REG_MAX_FREQ   = 3'd6;
  localparam logic [2:0] REG_MIN_FREQ   = 3'd7;

  localparam logic [6:0]  RST_RAISE_LOAD = 7'd75;
  localparam logic [6:0]  RST_BOOST_PCT  = 7'd85;
  localparam logic [3:0]  RST_FAST_DIV   = 4'd4;
  localparam logic [3:0]  RST_SLOW_MULT  = 4'd2;
  localparam logic [23:0] RST_BASE_IVL   = 24'd20000;
  localparam logic [23:0] RST_FLOOR_IVL  = 24'd10000;
  localparam logic [23:0] RST_MAX_FREQ   = 24'd2000000;
  localparam logic [23:0] RST_MIN_FREQ   = 24'd300000;

  typedef struct packed {
    logic [6:0]  raise_load;
    logic [6:0]  boost_pct;
    logic [3:0]  fast_div;
    logic [3:0]  slow_mult;
    logic [23:0] base_interval_us;
    logic [23:0] floor_interval_us;
    logic [23:0] max_freq_khz;
    logic [23:0] min_freq_khz;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic launch;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_LAUNCH = 5'b00100,
    S_DIV    = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dlg_regs.sv =====
// Configuration register file with APB-style access.
`default_nettype none
module dlg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dlg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [dlg_pkg::DATA_W-1:0]  pwdata,
  output logic      [dlg_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output dlg_pkg::cfg_t                    cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raise_load        <= dlg_pkg::RST_RAISE_LOAD;
      cfg.boost_pct         <= dlg_pkg::RST_BOOST_PCT;
      cfg.fast_div          <= dlg_pkg::RST_FAST_DIV;
      cfg.slow_mult         <= dlg_pkg::RST_SLOW_MULT;
      cfg.base_interval_us  <= dlg_pkg::RST_BASE_IVL;
      cfg.floor_interval_us <= dlg_pkg::RST_FLOOR_IVL;
      cfg.max_freq_khz      <= dlg_pkg::RST_MAX_FREQ;
      cfg.min_freq_khz      <= dlg_pkg::RST_MIN_FREQ;
    end else if (wr) begin
      unique case (idx)
        dlg_pkg::REG_RAISE_LOAD: cfg.raise_load        <= pwdata[6:0];
        dlg_pkg::REG_BOOST_PCT:  cfg.boost_pct         <= pwdata[6:0];
        dlg_pkg::REG_FAST_DIV:   cfg.fast_div          <= pwdata[3:0];
        dlg_pkg::REG_SLOW_MULT:  cfg.slow_mult         <= pwdata[3:0];
        dlg_pkg::REG_BASE_IVL:   cfg.base_interval_us  <= pwdata[23:0];
        dlg_pkg::REG_FLOOR_IVL:  cfg.floor_interval_us <= pwdata[23:0];
        dlg_pkg::REG_MAX_FREQ:   cfg.max_freq_khz      <= pwdata[23:0];
        dlg_pkg::REG_MIN_FREQ:   cfg.min_freq_khz      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dlg_pkg::REG_RAISE_LOAD: prdata = {25'b0, cfg.raise_load};
      dlg_pkg::REG_BOOST_PCT:  prdata = {25'b0, cfg.boost_pct};
      dlg_pkg::REG_FAST_DIV:   prdata = {28'b0, cfg.fast_div};
      dlg_pkg::REG_SLOW_MULT:  prdata = {28'b0, cfg.slow_mult};
      dlg_pkg::REG_BASE_IVL:   prdata = {8'b0, cfg.base_interval_us};
      dlg_pkg::REG_FLOOR_IVL:  prdata = {8'b0, cfg.floor_interval_us};
      dlg_pkg::REG_MAX_FREQ:   prdata = {8'b0, cfg.max_freq_khz};
      dlg_pkg::REG_MIN_FREQ:   prdata = {8'b0, cfg.min_freq_khz};
      default:                 prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dlg_div.sv =====
// Restoring divider, two quotient bits per cycle.
`default_nettype none
module dlg_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [dlg_pkg::DIV_W-1:0]   dividend,
  input  wire logic [dlg_pkg::DVS_W-1:0]   divisor,
  output logic                             done,
  output logic      [dlg_pkg::DIV_W-1:0]   quotient
);

  logic                          busy;
  logic [dlg_pkg::CNT_W-1:0]     cnt;
  logic [dlg_pkg::DVS_W-1:0]     rem;
  logic [dlg_pkg::DIV_W-1:0]     quo;
  logic [dlg_pkg::DVS_W-1:0]     dvs;

  logic [dlg_pkg::DVS_W:0]       r1, r2, d_ext;
  logic                          ge1, ge2;
  logic [dlg_pkg::DVS_W-1:0]     r1n, rem_next;
  logic [dlg_pkg::DIV_W-1:0]     q1, quo_next;

  always_comb begin
    d_ext    = {1'b0, dvs};
    r1       = {rem, quo[dlg_pkg::DIV_W-1]};
    ge1      = r1 >= d_ext;
    r1n      = ge1 ? 7'(r1 - d_ext) : r1[dlg_pkg::DVS_W-1:0];
    q1       = {quo[dlg_pkg::DIV_W-2:0], ge1};
    r2       = {r1n, q1[dlg_pkg::DIV_W-1]};
    ge2      = r2 >= d_ext;
    rem_next = ge2 ? 7'(r2 - d_ext) : r2[dlg_pkg::DVS_W-1:0];
    quo_next = {q1[dlg_pkg::DIV_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == dlg_pkg::CNT_W'(dlg_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

// ===== hw/rtl/dlg_dp.sv =====
// Datapath: operand capture, products, reciprocal scaling, divider, target and interval update.
`default_nettype none
module dlg_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dlg_pkg::cfg_t                 cfg,
  input  wire dlg_pkg::cmd_t                 cmd,
  output dlg_pkg::sts_t                      sts,
  input  wire logic                          action,
  input  wire logic [dlg_pkg::PCT_W-1:0]     load_pct,
  input  wire logic [dlg_pkg::FREQ_W-1:0]    current_khz,
  output logic      [dlg_pkg::FREQ_W-1:0]    request_khz,
  output logic      [1:0]                    relation,
  output logic      [dlg_pkg::IVL_W-1:0]     next_interval_us
);

  logic                          act;
  logic [dlg_pkg::PCT_W-1:0]     load;
  logic [dlg_pkg::FREQ_W-1:0]    cur;
  logic [dlg_pkg::FREQ_W-1:0]    target;
  logic [30:0]                   prod;
  logic [27:0]                   imul;
  logic [62:0]                   recip;
  logic [24:0]                   qa;

  logic                          is_busy, is_idle;
  logic [dlg_pkg::PCT_W-1:0]     pct;
  logic [3:0]                    bd1, im1;
  logic                          done_b;
  logic [dlg_pkg::DIV_W-1:0]     qb;

  logic [dlg_pkg::FREQ_W-1:0]    hs, lowered, target_next;
  logic [dlg_pkg::FREQ_W:0]      floor_sum;
  logic [dlg_pkg::IVL_W-1:0]     ivl_raw, ivl_next;
  logic [1:0]                    rel_next;

  assign is_busy = load > cfg.raise_load;
  assign is_idle = load < dlg_pkg::IDLE_LOAD;
  assign pct     = is_busy ? cfg.boost_pct : dlg_pkg::DROP_PCT;
  assign bd1     = (cfg.fast_div == 4'd0) ? 4'd1 : cfg.fast_div;
  assign im1     = (cfg.slow_mult == 4'd0) ? 4'd1 : cfg.slow_mult;
  assign recip   = {32'b0, prod} * {31'b0, dlg_pkg::RECIP_100};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act  <= action;
      load <= load_pct;
      cur  <= current_khz;
    end
    if (cmd.mul) begin
      prod <= {24'b0, pct} * {7'b0, cfg.max_freq_khz};
      imul <= {4'b0, cfg.base_interval_us} * {24'b0, im1};
    end
    if (cmd.launch) begin
      qa <= recip[62:dlg_pkg::RECIP_SH];
    end
  end

  dlg_div u_div_ivl (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.launch),
    .dividend ({8'b0, cfg.base_interval_us}),
    .divisor  ({3'b0, bd1}),
    .done     (done_b),
    .quotient (qb)
  );

  assign sts.div_done = done_b;

  always_comb begin
    hs        = qa[24] ? dlg_pkg::FREQ_MAX : qa[23:0];
    floor_sum = {1'b0, cfg.min_freq_khz} + {1'b0, qa[23:0]};
    lowered   = ({1'b0, target} < floor_sum) ? cfg.min_freq_khz : target - qa[23:0];
    priority if (act) begin
      target_next = cur;
      rel_next    = dlg_pkg::REL_NONE;
      ivl_raw     = '0;
    end else if (is_busy) begin
      target_next = (target >= hs) ? cfg.max_freq_khz : hs;
      rel_next    = dlg_pkg::REL_AT_BELOW;
      ivl_raw     = {3'b0, qb[23:0]};
    end else if (is_idle) begin
      target_next = lowered;
      rel_next    = dlg_pkg::REL_AT_ABOVE;
      ivl_raw     = imul[27] ? dlg_pkg::IVL_MAX : imul[26:0];
    end else begin
      target_next = target;
      rel_next    = dlg_pkg::REL_NONE;
      ivl_raw     = {3'b0, cfg.base_interval_us};
    end
    if (act) begin
      ivl_next = '0;
    end else if (ivl_raw < {3'b0, cfg.floor_interval_us}) begin
      ivl_next = {3'b0, cfg.floor_interval_us};
    end else begin
      ivl_next = ivl_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cmd.finish) begin
      target <= target_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      request_khz      <= target_next;
      relation         <= rel_next;
      next_interval_us <= ivl_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dlg_ctrl.sv =====
// Controller state machine: sequences capture, products, division and result load.
`default_nettype none
module dlg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           action,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dlg_pkg::cmd_t       cmd,
  input  wire dlg_pkg::sts_t  sts
);

  dlg_pkg::state_t state, state_next;
  logic            accept, out_free;

  assign in_stall = rst || (state != dlg_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.capture = accept;
    unique case (state)
      dlg_pkg::S_IDLE: begin
        if (accept) begin
          state_next = action ? dlg_pkg::S_FIN : dlg_pkg::S_MUL;
        end
      end
      dlg_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = dlg_pkg::S_LAUNCH;
      end
      dlg_pkg::S_LAUNCH: begin
        cmd.launch = 1'b1;
        state_next = dlg_pkg::S_DIV;
      end
      dlg_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_next = dlg_pkg::S_FIN;
        end
      end
      dlg_pkg::S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = dlg_pkg::S_IDLE;
        end
      end
      default: state_next = dlg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dlg_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> state == dlg_pkg::S_DIV)
    else $error("divider done outside divide state");
  a_start_short: assert property (@(posedge clk) disable iff (rst)
    accept && action |=> state == dlg_pkg::S_FIN)
    else $error("start word did not go to finish");
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid && state == dlg_pkg::S_IDLE)
    else $error("result not presented after finish");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/dvfs_load_governor_step_core.sv =====
// Top level of the DVFS load governor step.
// A load sample word passes the product, launch, divide and finish states after accept, and a
// start word goes straight to finish; finish waits while the output is stalled. A new word is
// taken only in idle; for a sample the interval divider retires two quotient bits per cycle.
// Reset: synchronous; clears the held target to 0, loads register defaults, drops valid.
`default_nettype none
module dvfs_load_governor_step_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dlg_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [dlg_pkg::DATA_W-1:0]    pwdata,
  output logic      [dlg_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic [dlg_pkg::PCT_W-1:0]     load_pct,
  input  wire logic [dlg_pkg::FREQ_W-1:0]    current_khz,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [dlg_pkg::FREQ_W-1:0]    request_khz,
  output logic      [1:0]                    relation,
  output logic      [dlg_pkg::IVL_W-1:0]     next_interval_us
);

  dlg_pkg::cfg_t cfg;
  dlg_pkg::cmd_t cmd;
  dlg_pkg::sts_t sts;

  dlg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dlg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dlg_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .action           (action),
    .load_pct         (load_pct),
    .current_khz      (current_khz),
    .request_khz      (request_khz),
    .relation         (relation),
    .next_interval_us (next_interval_us)
  );

endmodule
`default_nettype wire
